// File: design/msic_pkg.sv
package msic_pkg;

  // Field widths of the stream words and the configuration port.
  localparam int PERIOD_W    = 24;
  localparam int TARGET_W    = 20;
  localparam int SPEED_W     = 20;
  localparam int DUTY_W      = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 40;

  // Widths of the intermediate values of the integral update.
  localparam int ERR_W  = 21;
  localparam int PROD_W = 23;
  localparam int INC_W  = 17;
  localparam int SUM_W  = 18;

  localparam int PWM_PERIOD_DEFAULT = 40000;
  localparam int CEILING_MARGIN     = 100;

  // 800000000 / (period * 1024) equals 781250 / period, since 1024 divides
  // the numerator exactly.
  localparam logic [SPEED_W-1:0] SPEED_NUMER = 20'd781250;

  localparam logic [DUTY_W-1:0] FLOOR_RESET = 16'd100;
  localparam logic [DUTY_W-1:0] DUTY_RESET  = 16'd10000;

  localparam int GAIN_NUM   = 3;
  localparam int GAIN_SHIFT = 6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_GAIN,
    ST_CLAMP
  } ctrl_state_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DUTY_FLOOR   = 1'b0,
    CFG_DUTY_CEILING = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// File: design/msic_div.sv
// Restoring divider: SPEED_NUMER / divisor, one quotient bit per cycle.
module msic_div import msic_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [PERIOD_W-1:0] divisor,
  output logic [SPEED_W-1:0]  quotient,
  output div_status_t         status
);

  localparam int CNT_W = $clog2(SPEED_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(SPEED_W - 1);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [SPEED_W-1:0] quo_r, quo_nxt;
  logic [PERIOD_W-1:0] rem_r, rem_nxt;
  logic [PERIOD_W-1:0] dvs_r, dvs_nxt;

  logic [PERIOD_W:0] trial;
  logic [PERIOD_W:0] dvs_x;
  logic [PERIOD_W:0] diff;
  logic              ge;

  // The dividend shifts out of the top of quo_r while quotient bits enter
  // at the bottom.
  always_comb begin
    trial = {rem_r, quo_r[SPEED_W-1]};
    dvs_x = {1'b0, dvs_r};
    ge    = (trial >= dvs_x);
    diff  = trial - dvs_x;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = SPEED_NUMER;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[SPEED_W-2:0], ge};
      rem_nxt = ge ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quotient    = quo_r;
  assign status.busy = busy_r;
  assign status.done = done_r;

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("divider reports done while still stepping");

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while a division is in progress");

endmodule

// File: design/motor_speed_integral_controller.sv
// Channel  Direction  tdata bits (lowest first)                       Handshake
// in_      input      period [23:0], target_speed [43:24], zero pad   tvalid/tready
// out_     output     speed [19:0], duty [35:20], zero pad            tvalid/tready
// cfg_     input      index 0 duty_floor, index 1 duty_ceiling        cfg_we only
//
// A word is accepted only in IDLE; it then passes through DIV, GAIN and CLAMP
// before the block returns to IDLE and can accept the next word. In DIV the
// restoring divider produces one quotient bit per cycle, then reports done and
// the speed is latched. GAIN holds the gain step, CLAMP the sum and clamp, and
// IDLE has in_tready high. The result sits in an output
// register, so a stalled output only holds the block once the next result is
// ready to be written. Reset is synchronous and active low. It restores the
// floor to 100, the ceiling to PWM_PERIOD - 100 and the kept duty to 10000.
module motor_speed_integral_controller import msic_pkg::*; #(
  parameter int PWM_PERIOD = PWM_PERIOD_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // period [23:0], target_speed [43:24], bits [47:44] unused
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // speed [19:0], duty [35:20], bits [39:36] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [DUTY_W-1:0]      cfg_wdata
);

  localparam logic [DUTY_W-1:0] CEILING_RESET = DUTY_W'(PWM_PERIOD - CEILING_MARGIN);

  ctrl_state_t state_r, state_nxt;

  logic [DUTY_W-1:0]   floor_r, ceil_r, acc_r, acc_nxt;
  logic [TARGET_W-1:0] target_r;
  logic [SPEED_W-1:0]  speed_r;
  logic signed [INC_W-1:0] inc_r, inc_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [SPEED_W-1:0]  out_speed_r;
  logic [DUTY_W-1:0]   out_duty_r;

  logic [PERIOD_W-1:0] in_period;
  logic [TARGET_W-1:0] in_target;
  logic                in_fire;
  logic                out_free;
  logic                clamp_done;

  logic                div_start;
  logic [PERIOD_W-1:0] div_divisor;
  logic [SPEED_W-1:0]  div_quotient;
  div_status_t         div_status;

  logic signed [ERR_W-1:0]  err;
  logic signed [PROD_W-1:0] err_x, prod, prod_adj, prod_shr;
  logic signed [SUM_W-1:0]  sum, floor_x, ceil_x, clamped;

  assign in_period = in_tdata[PERIOD_W-1:0];
  assign in_target = in_tdata[PERIOD_W+TARGET_W-1:PERIOD_W];

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign clamp_done = (state_r == ST_CLAMP) && out_free;

  // A zero period reads as the maximum speed, which is exactly what a period
  // of one gives, so the divider simply sees one.
  assign div_start   = in_fire;
  assign div_divisor = (in_period == '0) ? PERIOD_W'(1) : in_period;

  msic_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (div_divisor),
    .quotient (div_quotient),
    .status   (div_status)
  );

  // Gain step: 3 * (target - speed) / 64 with truncation toward zero. A
  // negative product is biased by 63 before the arithmetic shift.
  always_comb begin
    err      = $signed({1'b0, target_r}) - $signed({1'b0, speed_r});
    err_x    = {{(PROD_W-ERR_W){err[ERR_W-1]}}, err};
    prod     = err_x * $signed(PROD_W'(GAIN_NUM));
    prod_adj = prod + (prod[PROD_W-1] ? PROD_W'((1 << GAIN_SHIFT) - 1) : '0);
    prod_shr = prod_adj >>> GAIN_SHIFT;
    inc_nxt  = prod_shr[INC_W-1:0];
  end

  // Sum and clamp. The floor is applied first and the ceiling second, so
  // crossed limits settle on the ceiling.
  always_comb begin
    sum     = $signed({2'b00, acc_r}) + $signed({inc_r[INC_W-1], inc_r});
    floor_x = $signed({2'b00, floor_r});
    ceil_x  = $signed({2'b00, ceil_r});
    clamped = sum;
    if (clamped < floor_x) begin
      clamped = floor_x;
    end
    if (clamped > ceil_x) begin
      clamped = ceil_x;
    end
    acc_nxt = clamp_done ? clamped[DUTY_W-1:0] : acc_r;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_status.done) begin
          state_nxt = ST_GAIN;
        end
      end
      ST_GAIN: begin
        state_nxt = ST_CLAMP;
      end
      ST_CLAMP: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (clamp_done) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      floor_r     <= FLOOR_RESET;
      ceil_r      <= CEILING_RESET;
      acc_r       <= DUTY_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      acc_r       <= acc_nxt;
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_DUTY_FLOOR:   floor_r <= cfg_wdata;
          CFG_DUTY_CEILING: ceil_r  <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      target_r <= in_target;
    end
    if ((state_r == ST_DIV) && div_status.done) begin
      speed_r <= div_quotient;
    end
    if (state_r == ST_GAIN) begin
      inc_r <= inc_nxt;
    end
    if (clamp_done) begin
      out_speed_r <= speed_r;
      out_duty_r  <= clamped[DUTY_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-SPEED_W-DUTY_W){1'b0}}, out_duty_r, out_speed_r};

  // The divider only finishes while the sequencer waits for it.
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_status.done |-> (state_r == ST_DIV))
    else $error("divider finished outside the divide state");

  // Input is never taken while the divider is stepping.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    div_status.busy |-> !in_tready)
    else $error("input ready while the divider is busy");

  // With ordered limits the kept duty lands inside them after each update.
  a_duty_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (clamp_done && (floor_r <= ceil_r)) |=>
      (out_valid_r && (acc_r >= floor_r) && (acc_r <= ceil_r)))
    else $error("updated duty outside the configured limits");

endmodule
